@@ hdl/ccd_pkg.sv @@
// Shared types, constants and character decode functions for the cheat code decoder.
package ccd_pkg;

   localparam int unsigned CountMax   = 15;
   localparam int unsigned LetterMax  = 8;
   localparam int unsigned HexFirst   = 2;
   localparam int unsigned HexDigits  = 6;
   localparam int unsigned RawLen     = 8;
   localparam int unsigned ShortLen   = 6;
   localparam int unsigned QueueDepth = 2;

   localparam logic [7:0] CharDash  = 8'h2D;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharTab   = 8'h09;

   typedef struct packed {
      logic       sep;
      logic       is_letter;
      logic [3:0] letter;
      logic       is_hex;
      logic [3:0] hex;
      logic       last;
   } class_type;

   typedef struct packed {
      logic       ok;
      logic       letter_form;
      logic [15:0] address;
      logic [7:0] value;
      logic       has_compare;
      logic [7:0] compare;
   } result_type;

   // Returns {valid, code} for the scrambled 16-letter alphabet.
   function automatic logic [4:0] letter_code(input logic [7:0] c);
      logic [7:0] u;
      logic [4:0] r;
      u = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         u = c - 8'h20;
      end
      unique case (u)
         8'h41:   r = {1'b1, 4'd0};   // A
         8'h50:   r = {1'b1, 4'd1};   // P
         8'h5A:   r = {1'b1, 4'd2};   // Z
         8'h4C:   r = {1'b1, 4'd3};   // L
         8'h47:   r = {1'b1, 4'd4};   // G
         8'h49:   r = {1'b1, 4'd5};   // I
         8'h54:   r = {1'b1, 4'd6};   // T
         8'h59:   r = {1'b1, 4'd7};   // Y
         8'h45:   r = {1'b1, 4'd8};   // E
         8'h4F:   r = {1'b1, 4'd9};   // O
         8'h58:   r = {1'b1, 4'd10};  // X
         8'h55:   r = {1'b1, 4'd11};  // U
         8'h4B:   r = {1'b1, 4'd12};  // K
         8'h53:   r = {1'b1, 4'd13};  // S
         8'h56:   r = {1'b1, 4'd14};  // V
         8'h4E:   r = {1'b1, 4'd15};  // N
         default: r = 5'd0;
      endcase
      return r;
   endfunction

   // Returns {valid, digit} for a hex character.
   function automatic logic [4:0] hex_code(input logic [7:0] c);
      logic [7:0] d;
      logic [4:0] r;
      r = 5'd0;
      d = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
         r = {1'b1, d[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
         r = {1'b1, d[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
         r = {1'b1, d[3:0]};
      end
      return r;
   endfunction

endpackage

@@ hdl/ccd_channels.sv @@
// Valid/ready channel interfaces for the character input and the decode result.
interface ccd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

interface ccd_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic        letter_form;
   logic [15:0] address;
   logic [7:0]  value;
   logic        has_compare;
   logic [7:0]  compare;

   modport source (output valid, output ok, output letter_form, output address,
                   output value, output has_compare, output compare, input ready);
   modport sink   (input valid, input ok, input letter_form, input address,
                   input value, input has_compare, input compare, output ready);
endinterface

@@ hdl/ccd_front.sv @@
// Front end: accepts characters and registers their classification.
module ccd_front (
   input  logic                clock,
   input  logic                reset,
   ccd_req_if.sink             req_chan,
   output logic                out_valid,
   input  logic                out_ready,
   output ccd_pkg::class_type  out_item
);
   import ccd_pkg::*;

   logic      valid_ff, valid_in;
   class_type item_ff, item_in;
   class_type cls;
   logic [4:0] let_c;
   logic [4:0] hex_c;
   logic       take;

   always_comb begin
      let_c         = letter_code(req_chan.ch);
      hex_c         = hex_code(req_chan.ch);
      cls.sep       = (req_chan.ch == CharDash) || (req_chan.ch == CharSpace) ||
                      (req_chan.ch == CharTab);
      cls.is_letter = let_c[4];
      cls.letter    = let_c[3:0];
      cls.is_hex    = hex_c[4];
      cls.hex       = hex_c[3:0];
      cls.last      = req_chan.last;
   end

   assign req_chan.ready = !valid_ff || out_ready;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = take || (valid_ff && !out_ready);
      item_in  = take ? cls : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ hdl/ccd_queue.sv @@
// Two-entry queue of classified items between front and back.
module ccd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ccd_pkg::class_type  in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output ccd_pkg::class_type  out_item
);
   import ccd_pkg::*;

   class_type  entry_ff [QueueDepth];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'(QueueDepth));
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

@@ hdl/ccd_back.sv @@
// Back end: gathers letter and hex digits, decodes on the last item, holds the result.
module ccd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ccd_pkg::class_type  in_item,
   ccd_rsp_if.source           rsp_chan
);
   import ccd_pkg::*;

   logic [3:0] letter_count_ff, letter_count_in;
   logic [3:0] letter_digits_ff [LetterMax];
   logic [3:0] letter_digits_in [LetterMax];
   logic       letters_valid_ff, letters_valid_in;
   logic [3:0] raw_count_ff, raw_count_in;
   logic [3:0] raw_hex_ff [HexDigits];
   logic [3:0] raw_hex_in [HexDigits];
   logic       hex_valid_ff, hex_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   result_type res;
   logic       out_free;
   logic       pop;
   logic [2:0] raw_idx;
   logic       let6, let8;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign in_ready = !in_item.last || out_free;
   assign pop      = in_valid && in_ready;
   assign raw_idx  = raw_count_ff[2:0] - 3'(HexFirst);

   always_comb begin
      letter_digits_in = letter_digits_ff;
      raw_hex_in       = raw_hex_ff;
      letter_count_in  = letter_count_ff;
      letters_valid_in = letters_valid_ff;
      raw_count_in     = raw_count_ff;
      hex_valid_in     = hex_valid_ff;

      if (raw_count_ff < 4'(RawLen)) begin
         if (!in_item.is_hex) begin
            hex_valid_in = 1'b0;
         end else if (raw_count_ff >= 4'(HexFirst)) begin
            raw_hex_in[raw_idx] = in_item.hex;
         end
      end
      if (raw_count_ff < 4'(CountMax)) begin
         raw_count_in = raw_count_ff + 4'd1;
      end

      if (!in_item.sep) begin
         if (!in_item.is_letter) begin
            letters_valid_in = 1'b0;
         end else if (letter_count_ff < 4'(LetterMax)) begin
            letter_digits_in[letter_count_ff[2:0]] = in_item.letter;
         end
         if (letter_count_ff < 4'(CountMax)) begin
            letter_count_in = letter_count_ff + 4'd1;
         end
      end
   end

   always_comb begin
      res  = '0;
      let6 = (letter_count_in == 4'(ShortLen));
      let8 = (letter_count_in == 4'(LetterMax));
      if (letters_valid_in && (let6 || let8)) begin
         res.ok          = 1'b1;
         res.letter_form = 1'b1;
         res.address   = {1'b1, letter_digits_in[3][2:0], letter_digits_in[4][3],
                          letter_digits_in[5][2:0], letter_digits_in[1][3],
                          letter_digits_in[2][2:0], letter_digits_in[3][3],
                          letter_digits_in[4][2:0]};
         res.value     = {letter_digits_in[0][3], letter_digits_in[1][2:0],
                          (let6 ? letter_digits_in[5][3] : letter_digits_in[7][3]),
                          letter_digits_in[0][2:0]};
         if (let8) begin
            res.has_compare = 1'b1;
            res.compare     = {letter_digits_in[6][3], letter_digits_in[7][2:0],
                               letter_digits_in[5][3], letter_digits_in[6][2:0]};
         end
      end else if (hex_valid_in && (raw_count_in == 4'(RawLen))) begin
         res.ok      = 1'b1;
         res.address = {raw_hex_in[0], raw_hex_in[1], raw_hex_in[2], raw_hex_in[3]};
         res.value   = {raw_hex_in[4], raw_hex_in[5]};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in       = rsp_ff;
      if (pop && in_item.last) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letter_count_ff  <= 4'd0;
         letters_valid_ff <= 1'b1;
         raw_count_ff     <= 4'd0;
         hex_valid_ff     <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            if (in_item.last) begin
               letter_count_ff  <= 4'd0;
               letters_valid_ff <= 1'b1;
               raw_count_ff     <= 4'd0;
               hex_valid_ff     <= 1'b1;
            end else begin
               letter_count_ff  <= letter_count_in;
               letters_valid_ff <= letters_valid_in;
               raw_count_ff     <= raw_count_in;
               hex_valid_ff     <= hex_valid_in;
            end
         end
      end
      if (pop) begin
         letter_digits_ff <= letter_digits_in;
         raw_hex_ff       <= raw_hex_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.ok          = rsp_ff.ok;
   assign rsp_chan.letter_form = rsp_ff.letter_form;
   assign rsp_chan.address     = rsp_ff.address;
   assign rsp_chan.value       = rsp_ff.value;
   assign rsp_chan.has_compare = rsp_ff.has_compare;
   assign rsp_chan.compare     = rsp_ff.compare;

endmodule

@@ hdl/cheat_code_decoder.sv @@
// Cheat code decoder top level: front end, item queue and back end.
//
// Characters of one code enter on req_chan, one item per cycle while
// req_chan.ready is high, with last marking the final character. Each code
// yields one item on rsp_chan: ok, letter_form, address, value, has_compare
// and compare, all fields zero when neither the letter nor the hex form decodes.
// Throughput is one character per cycle while req_chan.ready stays high, set by
// the update of the digit registers in the back end. After the edge that
// accepts the last character, the result passes the front register, the queue
// and the result register before it is valid on rsp_chan.
// A two-entry queue sits between front and back; when rsp_chan stalls the
// result register holds, characters of the next code keep flowing into the
// back end, and only its next last character waits. The queue then fills and
// req_chan.ready drops.
// Synchronous reset empties the pipeline, clears the counters and sets the flags;
// the block accepts items in the first cycle after reset.
module cheat_code_decoder (
   input  logic       clock,
   input  logic       reset,
   ccd_req_if.sink    req_chan,
   ccd_rsp_if.source  rsp_chan
);
   import ccd_pkg::*;

   logic      front_valid, front_ready;
   class_type front_item;
   logic      back_valid, back_ready;
   class_type back_item;

   ccd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   ccd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_item  (back_item)
   );

   ccd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (back_valid),
      .in_ready (back_ready),
      .in_item  (back_item),
      .rsp_chan (rsp_chan)
   );

endmodule
